// ----- rtl/core/vti_pkg.sv -----
// ----------------------------------------------------------------------------
// vti_pkg
// Shared types and constants for the VLAN tag tuple index generator.
// ----------------------------------------------------------------------------
package vti_pkg;

   localparam int IDX_W     = 64;
   localparam int TAG_W     = 12;
   localparam int MAX_TAGS  = 2;
   localparam int TUPLE_W   = 24;
   localparam int SIZE_W    = 24;
   localparam int CNT_W     = 2;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 24;

   localparam logic [TAG_W-1:0] TAG_RADIX = 12'd4095;

   // Register indexes on the CSR port
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_TAGS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TAG_COUNT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_SIZE = 2'd2;

   // One stage of the remainder pipeline
   typedef struct packed {
      logic              valid;
      logic [SIZE_W-1:0] rem;
      logic [IDX_W-1:0]  idx;
   } div_stage_type;

endpackage

// ----- rtl/core/vti_div_stage.sv -----
// ----------------------------------------------------------------------------
// vti_div_stage
// One restoring step of index modulo range size: shifts in the next index bit
// and subtracts the divisor when it fits.
// ----------------------------------------------------------------------------
module vti_div_stage (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic [vti_pkg::SIZE_W-1:0]  divisor,
   input  vti_pkg::div_stage_type      stage_in,
   output vti_pkg::div_stage_type      stage_out
);
   import vti_pkg::*;

   logic [SIZE_W:0]   trial;
   logic [SIZE_W:0]   diff;
   div_stage_type     stage_in_ff;
   div_stage_type     stage_next;

   // Shift in the top index bit and conditionally subtract
   always_comb begin
      trial = {stage_in.rem, stage_in.idx[IDX_W-1]};
      diff  = trial - {1'b0, divisor};
      stage_next.valid = stage_in.valid;
      stage_next.idx   = {stage_in.idx[IDX_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
         stage_next.rem = diff[SIZE_W-1:0];
      end else begin
         stage_next.rem = trial[SIZE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_in_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_in_ff.valid <= stage_next.valid;
      end
      if (advance) begin
         stage_in_ff.rem <= stage_next.rem;
         stage_in_ff.idx <= stage_next.idx;
      end
   end

   assign stage_out = stage_in_ff;

endmodule

// ----- rtl/core/vti_digit_unit.sv -----
// ----------------------------------------------------------------------------
// vti_digit_unit
// Adds the reduced index to the first tuple in base 4095, one tag per stage,
// and holds the result transaction.
// ----------------------------------------------------------------------------
module vti_digit_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  vti_pkg::div_stage_type        stage_in,
   input  logic [vti_pkg::TUPLE_W-1:0]   first_tags,
   input  logic [vti_pkg::CNT_W-1:0]     tag_count,
   input  logic                          range_empty,
   output logic                          rsp_valid,
   output logic [vti_pkg::TUPLE_W-1:0]   rsp_tags,
   output logic                          rsp_range_empty
);
   import vti_pkg::*;

   // Reduce a value below 2^14 modulo 4095 (2^12 is 1 mod 4095)
   function automatic logic [TAG_W-1:0] mod_radix(input logic [TAG_W+1:0] x);
      logic [TAG_W:0] s;
      s = {1'b0, x[TAG_W-1:0]} + {{(TAG_W-1){1'b0}}, x[TAG_W+1:TAG_W]};
      if (s >= {1'b0, TAG_RADIX}) begin
         s = s - {1'b0, TAG_RADIX};
      end
      return s[TAG_W-1:0];
   endfunction

   logic [SIZE_W:0]   sum0;
   logic [TAG_W:0]    hi0;
   logic [TAG_W+1:0]  s1;
   logic [TAG_W:0]    s2;
   logic              ge0;
   logic [TAG_W:0]    carry0;
   logic [TAG_W-1:0]  tag0;
   logic              use0;
   logic              use1;

   logic              valid1_ff;
   logic [TAG_W-1:0]  tag0_ff;
   logic [TAG_W:0]    carry_ff;
   logic              use1_ff;
   logic              empty1_ff;

   logic [TAG_W+1:0]  sum1;
   logic [TAG_W-1:0]  tag1;

   logic                rsp_valid_ff;
   logic [TUPLE_W-1:0]  rsp_tags_ff;
   logic                rsp_empty_ff;

   // Innermost digit: value, modulo and carry
   always_comb begin
      use0   = (tag_count != '0);
      use1   = (tag_count >= CNT_W'(MAX_TAGS));
      sum0   = {1'b0, stage_in.rem} + {{(SIZE_W-TAG_W+1){1'b0}}, first_tags[TAG_W-1:0]};
      hi0    = sum0[SIZE_W:TAG_W];
      s1     = {1'b0, hi0} + {2'b00, sum0[TAG_W-1:0]};
      s2     = {1'b0, s1[TAG_W-1:0]} + {{(TAG_W-1){1'b0}}, s1[TAG_W+1:TAG_W]};
      ge0    = (s2 >= {1'b0, TAG_RADIX});
      tag0   = ge0 ? TAG_W'(s2 - {1'b0, TAG_RADIX}) : s2[TAG_W-1:0];
      carry0 = hi0 + {{(TAG_W-1){1'b0}}, s1[TAG_W+1:TAG_W]} + {{TAG_W{1'b0}}, ge0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
      end else if (advance) begin
         valid1_ff <= stage_in.valid;
      end
      if (advance) begin
         tag0_ff   <= use0 ? tag0 : '0;
         carry_ff  <= carry0;
         use1_ff   <= use1;
         empty1_ff <= range_empty;
      end
   end

   // Outer digit takes the carry
   always_comb begin
      sum1 = {1'b0, carry_ff} + {2'b00, first_tags[TUPLE_W-1:TAG_W]};
      tag1 = mod_radix(sum1);
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= valid1_ff;
      end
      if (advance) begin
         rsp_empty_ff <= empty1_ff;
         if (empty1_ff) begin
            rsp_tags_ff <= '0;
         end else begin
            rsp_tags_ff <= {(use1_ff ? tag1 : {TAG_W{1'b0}}), tag0_ff};
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_tags        = rsp_tags_ff;
   assign rsp_range_empty = rsp_empty_ff;

endmodule

// ----- rtl/core/vlan_tuple_index_generator.sv -----
// ----------------------------------------------------------------------------
// vlan_tuple_index_generator
// Maps an index to the matching stacked VLAN tag tuple of a configured range.
// ----------------------------------------------------------------------------
// One transaction enters per cycle while the pipe is not stalled; each result
// passes 64 stages of the modulo pipeline (one index bit per stage) and two
// base-4095 digit stages, the last being the output register. The whole pipe
// advances together and halts only while a result is held under rsp_stall.
module vlan_tuple_index_generator (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [vti_pkg::IDX_W-1:0]          req_index,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [vti_pkg::TUPLE_W-1:0]        rsp_tags,
   output logic                               rsp_range_empty,
   input  logic                               csr_write,
   input  logic [vti_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [vti_pkg::CSR_DAT_W-1:0]      csr_wdata
);
   import vti_pkg::*;

   logic [TUPLE_W-1:0] first_tags_ff;
   logic [CNT_W-1:0]   tag_count_ff;
   logic [SIZE_W-1:0]  range_size_ff;
   logic               advance;
   div_stage_type      stage [0:IDX_W];

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         first_tags_ff <= '0;
         tag_count_ff  <= CNT_W'(1);
         range_size_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_FIRST_TAGS: first_tags_ff <= csr_wdata[TUPLE_W-1:0];
            CSR_TAG_COUNT:  tag_count_ff  <= csr_wdata[CNT_W-1:0];
            CSR_RANGE_SIZE: range_size_ff <= csr_wdata[SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   // Global pipeline enable
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   always_comb begin
      stage[0].valid = req_valid;
      stage[0].rem   = '0;
      stage[0].idx   = req_index;
   end

   // Remainder pipeline
   for (genvar k = 0; k < IDX_W; k++) begin : g_div
      vti_div_stage u_div (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .divisor   (range_size_ff),
         .stage_in  (stage[k]),
         .stage_out (stage[k+1])
      );
   end

   vti_digit_unit u_digit (
      .clock           (clock),
      .reset           (reset),
      .advance         (advance),
      .stage_in        (stage[IDX_W]),
      .first_tags      (first_tags_ff),
      .tag_count       (tag_count_ff),
      .range_empty     (range_size_ff == '0),
      .rsp_valid       (rsp_valid),
      .rsp_tags        (rsp_tags),
      .rsp_range_empty (rsp_range_empty)
   );

   // Checks
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_range_empty |-> rsp_tags == '0)
      else $error("empty range result carries tags");

   a_tag_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_range_empty |->
         rsp_tags[TAG_W-1:0] != TAG_RADIX && rsp_tags[TUPLE_W-1:TAG_W] != TAG_RADIX)
      else $error("tag out of base-4095 range");

   a_hold_pipe: assert property (@(posedge clock) disable iff (reset)
      req_stall |=> $stable(stage[IDX_W].rem) && $stable(stage[1].valid))
      else $error("pipeline moved while stalled");

endmodule

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// VLAN tag tuple index generator testbench
// Drives random and corner-case indexes through several register settings and
// checks every returned tuple against a behavioral model of the block. The
// sender and receiver idle in several phases.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import vti_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int PIPE_DRAIN     = 80;

   // register index with no register behind it
   localparam logic [CSR_IDX_W-1:0] CSR_NO_REG = 2'd3;

   typedef struct {
      logic [TUPLE_W-1:0] tags;
      logic               range_empty;
   } tuple_rsp_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [IDX_W-1:0]   req_index = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [TUPLE_W-1:0] rsp_tags;
   logic               rsp_range_empty;
   logic               csr_write = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_wdata = '0;

   // model copy of the registers
   logic [TUPLE_W-1:0] cfg_first_tags = '0;
   logic [CNT_W-1:0]   cfg_tag_count  = 2'd1;
   logic [SIZE_W-1:0]  cfg_range_size = '0;

   logic [IDX_W-1:0] pending_index_q[$];
   tuple_rsp_type    expected_tuple_q[$];
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   int  error_count = 0;
   int  quiet_cycles = 0;
   int  accepted_count = 0;

   vlan_tuple_index_generator dut (.*);

   always #5 clock = ~clock;

   // n-th tuple of the configured range
   function automatic tuple_rsp_type tuple_at_index(logic [IDX_W-1:0] n);
      tuple_rsp_type r;
      int unsigned used;
      logic [63:0] sum;
      logic [63:0] digit;
      r.tags = '0;
      r.range_empty = 1'b0;
      used = cfg_tag_count;
      if (used > MAX_TAGS) used = MAX_TAGS;
      if (cfg_range_size == 0) begin
         r.range_empty = 1'b1;
         return r;
      end
      sum = n % 64'(cfg_range_size);
      for (int k = 0; k < used; k++) begin
         digit = 64'(cfg_first_tags[k*TAG_W +: TAG_W]);
         sum = sum + digit;
         r.tags[k*TAG_W +: TAG_W] = TAG_W'(sum % 64'd4095);
         sum = sum / 64'd4095;
      end
      return r;
   endfunction

   // driver: one request transaction at a time from the pending queue
   always @(posedge clock) begin
      if (!reset) begin
         if (!req_valid || !req_stall) begin
            if (req_valid) begin
               expected_tuple_q.push_back(tuple_at_index(req_index));
               accepted_count <= accepted_count + 1;
            end
            if (pending_index_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_index <= pending_index_q.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: check response transactions, drive stall, run the watchdog
   always @(posedge clock) begin
      tuple_rsp_type exp_r;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_tuple_q.size() == 0) begin
               $error("unexpected response tags=%h range_empty=%b",
                      rsp_tags, rsp_range_empty);
               error_count++;
            end else begin
               exp_r = expected_tuple_q.pop_front();
               if (rsp_tags !== exp_r.tags) begin
                  $error("tags: expected %h actual %h", exp_r.tags, rsp_tags);
                  error_count++;
               end
               if (rsp_range_empty !== exp_r.range_empty) begin
                  $error("range_empty: expected %b actual %b",
                         exp_r.range_empty, rsp_range_empty);
                  error_count++;
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall) || csr_write)
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   task automatic csr_set(logic [CSR_IDX_W-1:0] idx, logic [CSR_DAT_W-1:0] val);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         CSR_FIRST_TAGS: cfg_first_tags = val;
         CSR_TAG_COUNT:  cfg_tag_count  = val[CNT_W-1:0];
         CSR_RANGE_SIZE: cfg_range_size = val;
         default: ;
      endcase
   endtask

   // poll between edges so that queue and valid updates have all settled
   task automatic drain_pipe();
      do begin
         @(negedge clock);
      end while (pending_index_q.size() != 0 || req_valid ||
                 expected_tuple_q.size() != 0);
      repeat (PIPE_DRAIN) @(posedge clock);
   endtask

   function automatic logic [IDX_W-1:0] rand_index();
      logic [IDX_W-1:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(3))
         0: v = v & 64'hFFFF;
         1: v = v & 64'hFFFF_FFFF;
         default: ;
      endcase
      return v;
   endfunction

   task automatic random_phase(int count);
      for (int i = 0; i < count; i++) pending_index_q.push_back(rand_index());
      drain_pipe();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset settings: empty range
      pending_index_q.push_back('0);
      pending_index_q.push_back('1);
      drain_pipe();

      // directed: two tags, start at top digits, large range
      csr_set(CSR_FIRST_TAGS, {12'hFFF, 12'hFFF});
      csr_set(CSR_TAG_COUNT, CSR_DAT_W'(2));
      csr_set(CSR_RANGE_SIZE, 24'd16769025);
      pending_index_q.push_back('0);
      pending_index_q.push_back('1);
      pending_index_q.push_back(64'd4094);
      pending_index_q.push_back(64'd4095);
      pending_index_q.push_back(64'd16769024);
      pending_index_q.push_back(64'd16769025);
      pending_index_q.push_back(64'h8000_0000_0000_0000);
      pending_index_q.push_back(64'hAAAA_AAAA_AAAA_AAAA);
      pending_index_q.push_back(64'h5555_5555_5555_5555);
      drain_pipe();

      // zero tag count, excess tag count, maximum range size register value
      csr_set(CSR_TAG_COUNT, CSR_DAT_W'(0));
      pending_index_q.push_back(64'd12345);
      drain_pipe();
      csr_set(CSR_TAG_COUNT, CSR_DAT_W'(3));
      csr_set(CSR_RANGE_SIZE, 24'hFFFFFF);
      csr_set(CSR_FIRST_TAGS, 24'h123FFE);
      pending_index_q.push_back('1);
      pending_index_q.push_back(64'd3);
      drain_pipe();

      // out-of-range register index is ignored
      csr_set(CSR_NO_REG, 24'h000000);
      pending_index_q.push_back(64'd77);
      pending_index_q.push_back(64'hFFFF_FFFF_0000_0001);
      drain_pipe();

      // random phases with varied settings and idling
      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
            default: begin send_idle_pct = 16; recv_stall_pct = 16; end
         endcase
         csr_set(CSR_FIRST_TAGS, CSR_DAT_W'($urandom));
         csr_set(CSR_TAG_COUNT, CSR_DAT_W'($urandom_range(3)));
         case ($urandom_range(3))
            0: csr_set(CSR_RANGE_SIZE, CSR_DAT_W'($urandom_range(1, 16)));
            1: csr_set(CSR_RANGE_SIZE, 24'd16769025);
            2: csr_set(CSR_RANGE_SIZE, (ph == 5) ? 24'd0 : CSR_DAT_W'($urandom));
            default: csr_set(CSR_RANGE_SIZE, CSR_DAT_W'($urandom_range(1, 9000)));
         endcase
         random_phase(66);
      end
      send_idle_pct = 0;
      recv_stall_pct = 0;

      if (error_count == 0 && expected_tuple_q.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
